// ----- hw/rtl/mtrsm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the memory type range slot manager.
// No dependencies; used by every module of the block.
package mtrsm_pkg;

    localparam int FIELD_W   = 36;
    localparam int SIZE_W    = 37;
    localparam int TYPE_W    = 8;
    localparam int PAGE_BITS = 12;
    localparam int VALID_POS = 11;
    localparam int SCAN_CAP  = 8;

    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_UNSUPPORTED = 4'd1,
        ST_MISALIGNED  = 4'd2,
        ST_TOO_HIGH    = 4'd3,
        ST_NOT_POW2    = 4'd4,
        ST_BASE_ALIGN  = 4'd5,
        ST_BAD_TYPE    = 4'd6,
        ST_UNKNOWN     = 4'd7,
        ST_WC_OFF      = 4'd8,
        ST_NO_SLOT     = 4'd9
    } status_t;

    localparam logic [TYPE_W-1:0] MT_WC = 8'd1;
    localparam logic [TYPE_W-1:0] MT_R2 = 8'd2;
    localparam logic [TYPE_W-1:0] MT_R3 = 8'd3;
    localparam logic [TYPE_W-1:0] MT_WB = 8'd6;

    typedef struct packed {
        logic       ranges_ok;
        logic       wc_ok;
        logic [3:0] slots_in_use;
        logic [7:0] def_type;
        logic [5:0] phys_bits;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic check;
        logic scan;
        logic write;
        logic result;
    } dp_cmd_t;

    typedef struct packed {
        logic chk_fail;
        logic scan_empty;
        logic hit;
        logic last;
        logic take_any;
    } dp_sts_t;

endpackage

// ----- hw/rtl/mtrsm_regs.sv -----
`timescale 1ns / 1ps
// APB configuration registers of the slot manager.
// Depends on mtrsm_pkg (cfg_t).
module mtrsm_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mtrsm_pkg::cfg_t     cfg
);

    localparam logic [2:0] R_SUPPORT  = 3'd0;
    localparam logic [2:0] R_WC_OK    = 3'd1;
    localparam logic [2:0] R_SLOTS    = 3'd2;
    localparam logic [2:0] R_DEF_TYPE = 3'd3;
    localparam logic [2:0] R_PHYS     = 3'd4;

    mtrsm_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ranges_ok    <= 1'b1;
            cfg_reg.wc_ok        <= 1'b1;
            cfg_reg.slots_in_use <= 4'd8;
            cfg_reg.def_type     <= 8'd0;
            cfg_reg.phys_bits    <= 6'd36;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                R_SUPPORT:  cfg_reg.ranges_ok    <= pwdata[0];
                R_WC_OK:    cfg_reg.wc_ok        <= pwdata[0];
                R_SLOTS:    cfg_reg.slots_in_use <= pwdata[3:0];
                R_DEF_TYPE: cfg_reg.def_type     <= pwdata[7:0];
                R_PHYS:     cfg_reg.phys_bits    <= pwdata[5:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            R_SUPPORT:  prdata = {31'd0, cfg_reg.ranges_ok};
            R_WC_OK:    prdata = {31'd0, cfg_reg.wc_ok};
            R_SLOTS:    prdata = {28'd0, cfg_reg.slots_in_use};
            R_DEF_TYPE: prdata = {24'd0, cfg_reg.def_type};
            R_PHYS:     prdata = {26'd0, cfg_reg.phys_bits};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ----- hw/rtl/mtrsm_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine: check, scan, write, decode, respond.
// Depends on mtrsm_pkg (action_t, dp_cmd_t, dp_sts_t).
module mtrsm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          action,
    input  mtrsm_pkg::dp_sts_t  sts,
    output mtrsm_pkg::dp_cmd_t  cmd,
    output logic                busy,
    output logic                done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK1 = 7'b0000010,
        S_CHECK2 = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_WRITE  = 7'b0010000,
        S_DECODE = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (mtrsm_pkg::action_t'(action))
                        mtrsm_pkg::ACT_REQUEST: state_next = S_CHECK1;
                        mtrsm_pkg::ACT_LOAD:    state_next = S_WRITE;
                        default:                state_next = S_DECODE;
                    endcase
                end
            end
            S_CHECK1:
            begin
                cmd.prep   = 1'b1;
                state_next = S_CHECK2;
            end
            S_CHECK2:
            begin
                cmd.check = 1'b1;
                if (sts.chk_fail || sts.scan_empty)
                    state_next = S_DECODE;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                    state_next = S_WRITE;
                else if (sts.last)
                    state_next = sts.take_any ? S_WRITE : S_DECODE;
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.result = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

// ----- hw/rtl/mtrsm_dp.sv -----
`timescale 1ns / 1ps
// Datapath: operand capture, range checks, slot table, scan and decode.
// Depends on mtrsm_pkg (cfg_t, dp_cmd_t, dp_sts_t, codes).
module mtrsm_dp
#(
    parameter int SLOT_COUNT = 8,
    parameter int ADDR_BITS  = 36
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mtrsm_pkg::cfg_t     cfg,
    input  mtrsm_pkg::dp_cmd_t  cmd,
    output mtrsm_pkg::dp_sts_t  sts,
    input  logic [1:0]          action,
    input  logic [2:0]          slot_index,
    input  logic [35:0]         range_base,
    input  logic [35:0]         range_size,
    input  logic [7:0]          mem_type,
    input  logic [35:0]         raw_base,
    input  logic [35:0]         raw_mask,
    output logic [3:0]          status,
    output logic [2:0]          chosen_slot,
    output logic                slot_valid,
    output logic [35:0]         decoded_base,
    output logic [36:0]         decoded_size,
    output logic [7:0]          decoded_type
);

    localparam int IW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW       = ADDR_BITS;
    localparam int AW1      = ADDR_BITS + 1;
    localparam int SCAN_MAX = (SLOT_COUNT < mtrsm_pkg::SCAN_CAP) ? SLOT_COUNT
                                                                  : mtrsm_pkg::SCAN_CAP;

    // slot table
    logic [AW-1:0] base_mem_reg [SLOT_COUNT];
    logic [AW-1:0] mask_mem_reg [SLOT_COUNT];

    // captured beat
    mtrsm_pkg::action_t act_reg;
    logic [2:0]         idx_reg;
    logic [35:0]        rbase_reg;
    logic [35:0]        rsize_reg;
    logic [7:0]         rtype_reg;
    logic [35:0]        rawb_reg;
    logic [35:0]        rawm_reg;

    // check and scan state
    logic [36:0]        sum_reg;
    logic [35:0]        szm1_reg;
    mtrsm_pkg::status_t st_reg;
    mtrsm_pkg::status_t st_next;
    logic [2:0]         scan_i_reg;
    logic               found_reg;
    logic [IW-1:0]      sel_reg;

    // result
    logic [3:0]         status_reg;
    logic [2:0]         chosen_reg;
    logic               valid_reg;
    logic [35:0]        dbase_reg;
    logic [36:0]        dsize_reg;
    logic [7:0]         dtype_reg;

    logic [AW-1:0]      pmask;
    logic [3:0]         count;
    logic               idx_ok;
    logic [IW-1:0]      slot_addr;
    logic [IW-1:0]      rd_addr;
    logic [AW-1:0]      rd_base;
    logic [AW-1:0]      rd_mask;
    logic [AW-1:0]      size_x;
    logic [35:0]        rd_base36;
    logic               rd_valid;
    logic               hit;
    logic               free_now;
    logic [AW:0]        size_sum;

    always_comb
    begin
        for (int j = 0; j < AW; j++)
            pmask[j] = (int'(cfg.phys_bits) > j);
    end

    assign count  = (int'(cfg.slots_in_use) > SCAN_MAX) ? 4'(SCAN_MAX) : cfg.slots_in_use;
    assign idx_ok = (int'(idx_reg) < SLOT_COUNT);

    assign slot_addr = (act_reg == mtrsm_pkg::ACT_REQUEST) ? sel_reg : IW'(idx_reg);
    assign rd_addr   = cmd.scan ? IW'(scan_i_reg) : slot_addr;
    assign rd_base   = base_mem_reg[rd_addr];
    assign rd_mask   = mask_mem_reg[rd_addr];

    assign rd_valid  = rd_mask[mtrsm_pkg::VALID_POS];
    assign rd_base36 = 36'(rd_base) & ~36'hFFF;
    assign size_x    = pmask ^ (rd_mask & ~AW'(12'hFFF));
    assign size_sum  = {1'b0, size_x} + AW1'(1);

    assign hit      = rd_valid && (rd_base36 == rbase_reg)
                      && (37'(size_x) == {1'b0, szm1_reg});
    assign free_now = !rd_valid || (rd_base[7:0] == cfg.def_type);

    // range checks, priority order
    always_comb
    begin
        if (!cfg.ranges_ok)
            st_next = mtrsm_pkg::ST_UNSUPPORTED;
        else if ((rbase_reg[11:0] != 12'd0) || (rsize_reg[11:0] != 12'd0)
                 || (rsize_reg == 36'd0))
            st_next = mtrsm_pkg::ST_MISALIGNED;
        else if (64'(sum_reg) >= (64'd1 << AW))
            st_next = mtrsm_pkg::ST_TOO_HIGH;
        else if ((rsize_reg & szm1_reg) != 36'd0)
            st_next = mtrsm_pkg::ST_NOT_POW2;
        else if ((rbase_reg & szm1_reg) != 36'd0)
            st_next = mtrsm_pkg::ST_BASE_ALIGN;
        else if (rtype_reg > mtrsm_pkg::MT_WB)
            st_next = mtrsm_pkg::ST_BAD_TYPE;
        else if ((rtype_reg == mtrsm_pkg::MT_R2) || (rtype_reg == mtrsm_pkg::MT_R3))
            st_next = mtrsm_pkg::ST_UNKNOWN;
        else if ((rtype_reg == mtrsm_pkg::MT_WC) && !cfg.wc_ok)
            st_next = mtrsm_pkg::ST_WC_OFF;
        else
            st_next = mtrsm_pkg::ST_OK;
    end

    assign sts.chk_fail   = (st_next != mtrsm_pkg::ST_OK);
    assign sts.scan_empty = (count == 4'd0);
    assign sts.hit        = hit;
    assign sts.last       = ({1'b0, scan_i_reg} + 4'd1 == count);
    assign sts.take_any   = found_reg || free_now;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= mtrsm_pkg::action_t'(action);
            idx_reg   <= slot_index;
            rbase_reg <= range_base;
            rsize_reg <= range_size;
            rtype_reg <= mem_type;
            rawb_reg  <= raw_base;
            rawm_reg  <= raw_mask;
        end
        if (cmd.prep)
        begin
            sum_reg  <= {1'b0, rbase_reg} + {1'b0, rsize_reg};
            szm1_reg <= rsize_reg - 36'd1;
        end
        if (cmd.check)
            st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_i_reg <= 3'd0;
            found_reg  <= 1'b0;
            sel_reg    <= '0;
        end
        else if (cmd.check)
        begin
            scan_i_reg <= 3'd0;
            found_reg  <= 1'b0;
            sel_reg    <= '0;
        end
        else if (cmd.scan)
        begin
            scan_i_reg <= scan_i_reg + 3'd1;
            if (hit || (!found_reg && free_now))
            begin
                found_reg <= 1'b1;
                sel_reg   <= IW'(scan_i_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                base_mem_reg[k] <= '0;
                mask_mem_reg[k] <= '0;
            end
        end
        else if (cmd.write)
        begin
            if (act_reg == mtrsm_pkg::ACT_REQUEST && found_reg)
            begin
                base_mem_reg[slot_addr] <= AW'(rbase_reg | 36'(rtype_reg));
                mask_mem_reg[slot_addr] <= (pmask & ~AW'(szm1_reg))
                                           | (AW'(1) << mtrsm_pkg::VALID_POS);
            end
            else if (act_reg == mtrsm_pkg::ACT_LOAD && idx_ok)
            begin
                base_mem_reg[slot_addr] <= AW'(rawb_reg);
                mask_mem_reg[slot_addr] <= AW'(rawm_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            status_reg <= mtrsm_pkg::ST_OK;
            chosen_reg <= 3'd0;
            valid_reg  <= 1'b0;
            dbase_reg  <= 36'd0;
            dsize_reg  <= 37'd0;
            dtype_reg  <= 8'd0;
            case (act_reg)
                mtrsm_pkg::ACT_REQUEST:
                begin
                    if (st_reg != mtrsm_pkg::ST_OK)
                        status_reg <= st_reg;
                    else if (!found_reg)
                        status_reg <= mtrsm_pkg::ST_NO_SLOT;
                    else
                    begin
                        chosen_reg <= 3'(sel_reg);
                        valid_reg  <= rd_valid;
                        dbase_reg  <= rd_base36;
                        dsize_reg  <= 37'(size_sum);
                        dtype_reg  <= rd_base[7:0];
                    end
                end
                mtrsm_pkg::ACT_LOAD, mtrsm_pkg::ACT_READ:
                begin
                    chosen_reg <= idx_reg;
                    if (idx_ok)
                    begin
                        valid_reg <= rd_valid;
                        dbase_reg <= rd_base36;
                        dsize_reg <= 37'(size_sum);
                        dtype_reg <= rd_base[7:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign status       = status_reg;
    assign chosen_slot  = chosen_reg;
    assign slot_valid   = valid_reg;
    assign decoded_base = dbase_reg;
    assign decoded_size = dsize_reg;
    assign decoded_type = dtype_reg;

    a_write_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && act_reg == mtrsm_pkg::ACT_REQUEST)
            |-> (found_reg && st_reg == mtrsm_pkg::ST_OK))
        else $error("request write without a chosen slot");

    a_scan_range : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> ({1'b0, scan_i_reg} < count))
        else $error("scan past slot count");

    a_write_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && act_reg == mtrsm_pkg::ACT_REQUEST)
            |=> mask_mem_reg[$past(sel_reg)][mtrsm_pkg::VALID_POS])
        else $error("requested slot not marked valid");

endmodule

// ----- hw/rtl/memory_type_range_slot_manager.sv -----
`timescale 1ns / 1ps
// Top level of the memory type range slot manager.
// Depends on mtrsm_pkg, mtrsm_regs, mtrsm_ctrl, mtrsm_dp.
//
//  channel   handshake                  payload
//  command   start & !busy              action, slot_index, range_base, range_size,
//                                       mem_type, raw_base, raw_mask
//  result    done (one-cycle strobe)    status, chosen_slot, slot_valid, decoded_base,
//                                       decoded_size, decoded_type
//  config    psel & penable & pwrite    paddr, pwdata (prdata on reads, pready tied high)
//
// Result path: read or unused action goes decode, respond; load goes write, decode,
// respond; a rejected request, or one with no slots to scan, goes check, decode,
// respond; other requests go check, a scan of at most 8 slots that stops at an
// exact match, write if a slot was found, decode, respond. busy falls as done ends.
// The scan reads one table slot per cycle through a single read port.
// rst_n is asynchronous; it clears the slot table and loads register defaults.
// done cannot be stalled; the receiver takes every result.
module memory_type_range_slot_manager
#(
    parameter int SLOT_COUNT = 8,
    parameter int ADDR_BITS  = 36
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [2:0]  slot_index,
    input  logic [35:0] range_base,
    input  logic [35:0] range_size,
    input  logic [7:0]  mem_type,
    input  logic [35:0] raw_base,
    input  logic [35:0] raw_mask,
    output logic        done,
    output logic [3:0]  status,
    output logic [2:0]  chosen_slot,
    output logic        slot_valid,
    output logic [35:0] decoded_base,
    output logic [36:0] decoded_size,
    output logic [7:0]  decoded_type,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mtrsm_pkg::cfg_t    cfg;
    mtrsm_pkg::dp_cmd_t cmd;
    mtrsm_pkg::dp_sts_t sts;

    mtrsm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mtrsm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mtrsm_dp
    #(
        .SLOT_COUNT (SLOT_COUNT),
        .ADDR_BITS  (ADDR_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .slot_index   (slot_index),
        .range_base   (range_base),
        .range_size   (range_size),
        .mem_type     (mem_type),
        .raw_base     (raw_base),
        .raw_mask     (raw_mask),
        .status       (status),
        .chosen_slot  (chosen_slot),
        .slot_valid   (slot_valid),
        .decoded_base (decoded_base),
        .decoded_size (decoded_size),
        .decoded_type (decoded_type)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for memory_type_range_slot_manager: directed, register-corner
// and random command beats are checked against an in-bench slot table predictor.
// Depends on mtrsm_pkg and the memory_type_range_slot_manager RTL.
module testbench;
    import mtrsm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    localparam int REG_RANGES  = 0;
    localparam int REG_WC      = 1;
    localparam int REG_SLOTS   = 2;
    localparam int REG_DEFTYPE = 3;
    localparam int REG_PHYS    = 4;
    localparam int REG_COUNT   = 5;
    localparam logic [31:0] REG_MASK [REG_COUNT] = '{32'h1, 32'h1, 32'hF, 32'hFF, 32'h3F};

    localparam logic [7:0] MT_UC  = 8'd0;
    localparam logic [7:0] MT_WT  = 8'd4;
    localparam logic [7:0] MT_WP  = 8'd5;
    localparam logic [7:0] MT_BAD = 8'd7;
    localparam logic [7:0] GOOD_TYPES [5] = '{MT_UC, MT_WC, MT_WT, MT_WP, MT_WB};

    typedef struct packed {
        action_t     act;
        logic [2:0]  idx;
        logic [35:0] rbase;
        logic [35:0] rsize;
        logic [7:0]  mtype;
        logic [35:0] wbase;
        logic [35:0] wmask;
    } slot_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot;
        logic        valid;
        logic [35:0] base;
        logic [36:0] size;
        logic [7:0]  mtype;
    } slot_result_t;

    typedef struct packed {
        logic [35:0] base;
        logic [35:0] size;
        logic [7:0]  mtype;
    } range_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = '0;
    logic [2:0]  slot_index = '0;
    logic [35:0] range_base = '0;
    logic [35:0] range_size = '0;
    logic [7:0]  mem_type = '0;
    logic [35:0] raw_base = '0;
    logic [35:0] raw_mask = '0;
    logic        done;
    logic [3:0]  status;
    logic [2:0]  chosen_slot;
    logic        slot_valid;
    logic [35:0] decoded_base;
    logic [36:0] decoded_size;
    logic [7:0]  decoded_type;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    memory_type_range_slot_manager dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .slot_index(slot_index), .range_base(range_base),
        .range_size(range_size), .mem_type(mem_type), .raw_base(raw_base),
        .raw_mask(raw_mask), .done(done), .status(status), .chosen_slot(chosen_slot),
        .slot_valid(slot_valid), .decoded_base(decoded_base), .decoded_size(decoded_size),
        .decoded_type(decoded_type), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [35:0]  table_base [8];
    logic [35:0]  table_mask [8];
    cfg_t         model_cfg;
    range_t       recent_ranges [$];
    slot_result_t pending_outcomes [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  steady_sender = 1'b0;

    function automatic logic [35:0] rand36();
        logic [35:0] v;
        v[31:0]  = $urandom();
        v[35:32] = 4'($urandom_range(15, 0));
        return v;
    endfunction

    function automatic logic [35:0] phys_mask_now();
        int bits = (model_cfg.phys_bits > 36) ? 36 : int'(model_cfg.phys_bits);
        return 36'((37'd1 << bits) - 37'd1);
    endfunction

    function automatic slot_result_t decode_entry(int s);
        slot_result_t r;
        logic [35:0]  b;
        logic [35:0]  m;
        b = table_base[s];
        m = table_mask[s];
        r.status = ST_OK;
        r.slot   = 3'(s);
        r.valid  = m[VALID_POS];
        r.base   = {b[35:12], 12'h000};
        r.size   = {1'b0, phys_mask_now() ^ {m[35:12], 12'h000}} + 37'd1;
        r.mtype  = b[7:0];
        return r;
    endfunction

    function automatic status_t range_verdict(logic [35:0] b, logic [35:0] s, logic [7:0] t);
        logic [36:0] sum;
        sum = {1'b0, b} + {1'b0, s};
        if (!model_cfg.ranges_ok)
            return ST_UNSUPPORTED;
        if (b[11:0] != 0 || s[11:0] != 0 || s == 0)
            return ST_MISALIGNED;
        if (sum[36])
            return ST_TOO_HIGH;
        if ((s & (s - 36'd1)) != 0)
            return ST_NOT_POW2;
        if ((b & (s - 36'd1)) != 0)
            return ST_BASE_ALIGN;
        if (t > MT_WB)
            return ST_BAD_TYPE;
        if (t == MT_R2 || t == MT_R3)
            return ST_UNKNOWN;
        if (t == MT_WC && !model_cfg.wc_ok)
            return ST_WC_OFF;
        return ST_OK;
    endfunction

    function automatic slot_result_t predict_slot_outcome(slot_cmd_t c);
        slot_result_t r;
        slot_result_t d;
        status_t      st;
        int           pick;
        int           count;
        range_t       rr;
        r = '0;
        case (c.act)
            ACT_REQUEST:
            begin
                st = range_verdict(c.rbase, c.rsize, c.mtype);
                if (st != ST_OK)
                    r.status = st;
                else
                begin
                    count = (model_cfg.slots_in_use > SCAN_CAP) ? SCAN_CAP
                                                                : int'(model_cfg.slots_in_use);
                    pick = -1;
                    for (int i = 0; i < count; i++)
                    begin
                        d = decode_entry(i);
                        if (pick == -1 && (!d.valid || d.mtype == model_cfg.def_type))
                            pick = i;
                        if (d.valid && d.base == c.rbase && d.size == {1'b0, c.rsize})
                        begin
                            pick = i;
                            break;
                        end
                    end
                    if (pick < 0)
                        r.status = ST_NO_SLOT;
                    else
                    begin
                        table_base[pick] = c.rbase | {28'h0, c.mtype};
                        table_mask[pick] = (phys_mask_now() & ~(c.rsize - 36'd1))
                                         | (36'd1 << VALID_POS);
                        r = decode_entry(pick);
                        rr.base  = c.rbase;
                        rr.size  = c.rsize;
                        rr.mtype = c.mtype;
                        recent_ranges.push_back(rr);
                        if (recent_ranges.size() > 16)
                            void'(recent_ranges.pop_front());
                    end
                end
            end
            ACT_LOAD:
            begin
                table_base[c.idx] = c.wbase;
                table_mask[c.idx] = c.wmask;
                r = decode_entry(c.idx);
            end
            ACT_READ:
                r = decode_entry(c.idx);
            default: ;
        endcase
        return r;
    endfunction

    function automatic slot_cmd_t mk_cmd(action_t a, logic [2:0] i, logic [35:0] b,
                                         logic [35:0] s, logic [7:0] t,
                                         logic [35:0] wb, logic [35:0] wm);
        slot_cmd_t c;
        c.act   = a;
        c.idx   = i;
        c.rbase = b;
        c.rsize = s;
        c.mtype = t;
        c.wbase = wb;
        c.wmask = wm;
        return c;
    endfunction

    function automatic slot_cmd_t random_cmd();
        slot_cmd_t   c;
        int          roll;
        int          e;
        logic [35:0] sz;
        logic [36:0] sum;
        range_t      rr;
        c.act   = ACT_REQUEST;
        c.idx   = 3'($urandom_range(7, 0));
        c.rbase = rand36();
        c.rsize = rand36();
        c.mtype = 8'($urandom_range(255, 0));
        c.wbase = rand36();
        c.wmask = rand36();
        e  = ($urandom_range(3, 0) == 0) ? $urandom_range(35, 12) : $urandom_range(24, 12);
        sz = 36'd1 << e;
        roll = $urandom_range(99, 0);
        if (roll < 45)
        begin
            c.rsize = sz;
            c.rbase = c.rbase & ~(sz - 36'd1);
            sum = {1'b0, c.rbase} + {1'b0, sz};
            if (sum[36])
                c.rbase = c.rbase - sz;
            c.mtype = GOOD_TYPES[$urandom_range(4, 0)];
        end
        else if (roll < 55 && recent_ranges.size() > 0)
        begin
            rr = recent_ranges[$urandom_range(recent_ranges.size() - 1, 0)];
            c.rbase = rr.base;
            c.rsize = rr.size;
            c.mtype = rr.mtype;
        end
        else if (roll < 60)
        begin
            c.rsize = sz;
            c.rbase = ~(sz - 36'd1);
            c.mtype = GOOD_TYPES[$urandom_range(4, 0)];
        end
        else if (roll < 68)
        begin
            c.rsize = c.rsize >> $urandom_range(35, 0);
            if ($urandom_range(1, 0))
                c.rbase[11:0] = '0;
        end
        else if (roll < 84)
        begin
            c.act = ACT_LOAD;
            if ($urandom_range(1, 0))
                c.wmask[VALID_POS] = 1'b0;
            if ($urandom_range(2, 0) == 0)
                c.wbase[7:0] = model_cfg.def_type;
        end
        else if (roll < 96)
            c.act = ACT_READ;
        else
            c.act = ACT_NONE;
        return c;
    endfunction

    task automatic issue(slot_cmd_t c);
        @(posedge clk);
        if (!steady_sender && $urandom_range(99, 0) < 13)
            repeat ($urandom_range(16, 1)) @(posedge clk);
        start      <= 1'b1;
        action     <= c.act;
        slot_index <= c.idx;
        range_base <= c.rbase;
        range_size <= c.rsize;
        mem_type   <= c.mtype;
        raw_base   <= c.wbase;
        raw_mask   <= c.wmask;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_outcomes.push_back(predict_slot_outcome(c));
        start <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // APB write, then read back
    task automatic set_reg(int idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            REG_RANGES:  model_cfg.ranges_ok    = val[0];
            REG_WC:      model_cfg.wc_ok        = val[0];
            REG_SLOTS:   model_cfg.slots_in_use = val[3:0];
            REG_DEFTYPE: model_cfg.def_type     = val[7:0];
            REG_PHYS:    model_cfg.phys_bits    = val[5:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== (val & REG_MASK[idx]))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("reg %0d readback: expected %h got %h", idx,
                         val & REG_MASK[idx], prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(bit rs, bit wc, int slots, int def, int phys);
        wait_idle();
        set_reg(REG_RANGES, 32'(rs));
        set_reg(REG_WC, 32'(wc));
        set_reg(REG_SLOTS, 32'(slots));
        set_reg(REG_DEFTYPE, 32'(def));
        set_reg(REG_PHYS, 32'(phys));
    endtask

    always @(posedge clk)
    begin : result_check
        slot_result_t got;
        slot_result_t want;
        if (rst_n && done === 1'b1)
        begin
            got.status = status_t'(status);
            got.slot   = chosen_slot;
            got.valid  = slot_valid;
            got.base   = decoded_base;
            got.size   = decoded_size;
            got.mtype  = decoded_type;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status=%0d slot=%0d", status, chosen_slot);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                    || got.valid !== want.valid || got.base !== want.base
                    || got.size !== want.size || got.mtype !== want.mtype)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp st=%0d slot=%0d v=%b base=%h size=%h ",
                                  "type=%h / got st=%0d slot=%0d v=%b base=%h size=%h type=%h"},
                                 want.status, want.slot, want.valid, want.base, want.size,
                                 want.mtype, got.status, got.slot, got.valid, got.base,
                                 got.size, got.mtype);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        issue(mk_cmd(ACT_READ, 3'd0, '0, '0, MT_UC, '0, '0));
        issue(mk_cmd(ACT_NONE, 3'd7, '1, '1, 8'hFF, '1, '1));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h1800, 36'h1000, MT_WB, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h1000, 36'h0, MT_WB, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h2000, 36'h1800, MT_WB, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'hF_FFFF_F000, 36'h1000, MT_WB, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h0, 36'h3000, MT_WB, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h1000, 36'h2000, MT_WB, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h0, 36'h1000, MT_BAD, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h0, 36'h1000, 8'hFF, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h0, 36'h1000, MT_R2, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h0, 36'h1000, MT_R3, '0, '0));
        // fill every slot with a non-default type
        for (int i = 0; i < 8; i++)
            issue(mk_cmd(ACT_REQUEST, 3'd0, 36'(i) << 20, 36'h10_0000,
                         GOOD_TYPES[1 + (i % 4)], '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h30_0000, 36'h10_0000, GOOD_TYPES[4], '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h100_0000, 36'h10_0000, MT_WB, '0, '0));
        issue(mk_cmd(ACT_LOAD, 3'd7, '0, '0, MT_UC, '1, '1));
        issue(mk_cmd(ACT_LOAD, 3'd7, '0, '0, MT_UC, '0, '0));
        issue(mk_cmd(ACT_REQUEST, 3'd0, 36'h0, 36'h8_0000_0000, MT_UC, '0, '0));
        wait_idle();
    endtask

    task automatic test_config_corners();
        set_config(1'b0, 1'b1, 8, MT_UC, 36);
        repeat (40) issue(random_cmd());
        set_config(1'b1, 1'b0, 8, MT_WB, 36);
        repeat (40) issue(random_cmd());
        set_config(1'b1, 1'b1, 0, MT_UC, 36);
        repeat (40) issue(random_cmd());
        set_config(1'b1, 1'b1, 15, 255, 63);
        repeat (40) issue(random_cmd());
        set_config(1'b1, 1'b1, 1, MT_UC, 13);
        repeat (40) issue(random_cmd());
        set_config(1'b1, 1'b1, 3, MT_WP, 0);
        repeat (40) issue(random_cmd());
    endtask

    task automatic test_random();
        int slots;
        int def;
        int phys;
        for (int phase = 0; phase < 9; phase++)
        begin
            slots = ($urandom_range(4, 0) != 0) ? $urandom_range(8, 1) : $urandom_range(15, 0);
            def   = ($urandom_range(3, 0) != 0) ? GOOD_TYPES[$urandom_range(4, 0)]
                                                : $urandom_range(255, 0);
            phys  = ($urandom_range(4, 0) != 0) ? $urandom_range(36, 13) : $urandom_range(63, 0);
            set_config($urandom_range(19, 0) != 0, $urandom_range(1, 0), slots, def, phys);
            steady_sender = (phase == 4);
            repeat (200) issue(random_cmd());
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            table_base[i] = '0;
            table_mask[i] = '0;
        end
        model_cfg.ranges_ok    = 1'b1;
        model_cfg.wc_ok        = 1'b1;
        model_cfg.slots_in_use = 4'd8;
        model_cfg.def_type     = MT_UC;
        model_cfg.phys_bits    = 6'd36;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_corners();
        test_random();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mtrsm_pkg.sv
hw/rtl/mtrsm_regs.sv
hw/rtl/mtrsm_ctrl.sv
hw/rtl/mtrsm_dp.sv
hw/rtl/memory_type_range_slot_manager.sv
tb/sv/testbench.sv
